// ===== rtl/cda_pkg.sv =====
// Shared types, constants and calendar tables for the date arithmetic block.
// Used by cda_sub_unit and calendar_date_arithmetic_top; depends on nothing.
package cda_pkg;

  // Day count width and packed stream widths
  localparam int COUNT_BITS  = 21;
  localparam int IN_FIELDS_W = 46 + COUNT_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 49;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Day line widths: serials fit 23 bits, shifted sums carry the count too
  localparam int SER_W = 23;
  localparam int SUM_W = ((COUNT_BITS > SER_W) ? COUNT_BITS : SER_W) + 2;

  // Day line limits (years shifted up by one 400-year cycle)
  localparam int SER_LO     = 146097;   // 0001-01-01
  localparam int SER_HI     = 3798156;  // 10000-01-01
  localparam int DIFF_LIMIT = 3652058;
  localparam int YEAR_BIAS  = 399;      // shifted year minus one

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_DIFF = 2'd3
  } mode_t;

  localparam logic [1:0] REL_EQ    = 2'd0;
  localparam logic [1:0] REL_LESS  = 2'd1;
  localparam logic [1:0] REL_GREAT = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB_IDX = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [3:0] MONTH_DEC_IDX = 4'd11;

  // Conversion direction of the shared divide loop
  typedef enum logic {
    CONV_SERIAL = 1'b0,   // date -> day serial
    CONV_DATE   = 1'b1    // day serial -> date
  } conv_t;

  // Result of one shared subtract step
  typedef struct packed {
    logic [SER_W-1:0] diff;
    logic             ge;
  } sub_res_t;

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m == 4'd0) r = MONTH_JAN;
    else if (m > MONTH_DEC) r = MONTH_DEC;
    return r;
  endfunction

  // Days before month m (1..12), non leap
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // Month length by zero-based index, non leap
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] r;
    case (idx)
      4'd1:    r = 5'd28;
      4'd3:    r = 5'd30;
      4'd5:    r = 5'd30;
      4'd8:    r = 5'd30;
      4'd10:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // Divisor of each phase of the divide loop
  function automatic logic [SER_W-1:0] phase_div(input conv_t k, input logic [1:0] ph);
    logic [SER_W-1:0] r;
    case (ph)
      2'd0:    r = (k == CONV_DATE) ? SER_W'(146097) : SER_W'(400);
      2'd1:    r = (k == CONV_DATE) ? SER_W'(36524)  : SER_W'(100);
      2'd2:    r = (k == CONV_DATE) ? SER_W'(1461)   : SER_W'(4);
      default: r = (k == CONV_DATE) ? SER_W'(365)    : SER_W'(1);
    endcase
    return r;
  endfunction

  // Amount accumulated per subtraction: days for serial, years for date
  function automatic logic [SER_W-1:0] phase_inc(input conv_t k, input logic [1:0] ph);
    logic [SER_W-1:0] r;
    case (ph)
      2'd0:    r = (k == CONV_DATE) ? SER_W'(400) : SER_W'(146097);
      2'd1:    r = (k == CONV_DATE) ? SER_W'(100) : SER_W'(36524);
      2'd2:    r = (k == CONV_DATE) ? SER_W'(4)   : SER_W'(1461);
      default: r = (k == CONV_DATE) ? SER_W'(1)   : SER_W'(365);
    endcase
    return r;
  endfunction

  // Remainder marking a century / 400-year boundary (serial direction)
  function automatic logic [SER_W-1:0] rem_mark(input logic [1:0] ph);
    logic [SER_W-1:0] r;
    case (ph)
      2'd0:    r = SER_W'(399);
      2'd1:    r = SER_W'(99);
      2'd2:    r = SER_W'(3);
      default: r = '1;
    endcase
    return r;
  endfunction

  // Quotient marking a boundary (date direction)
  function automatic logic [5:0] quo_mark(input logic [1:0] ph);
    logic [5:0] r;
    case (ph)
      2'd1:    r = 6'd3;
      2'd2:    r = 6'd24;
      2'd3:    r = 6'd3;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/calendar_date_arithmetic_top.sv =====
// Top level of the Gregorian date arithmetic block: stream ports, sequencer
// and result register. Depends on cda_pkg and cda_sub_unit.

// One request is taken at a time; in_tready is high only while the sequencer
// is idle. Add and subtract convert the base date to a day serial, shift it
// and convert it back through one shared subtract unit, one subtraction per
// cycle, then walk the months. Difference converts both dates. A finished
// result waits in the output register and the next request can still be
// taken, but that request's result waits until the register is free. A
// shifted year outside 1 to 9999 sets range_error with a zero date.
module calendar_date_arithmetic_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_year, base_month, base_day, other_year, other_month, other_day,
  // day_count
  input  logic [cda_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_year, result_month, result_day, relation, day_difference,
  // range_error
  output logic [cda_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import cda_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_SER_END = 6'b000100,
    ST_SHIFT   = 6'b001000,
    ST_MONTH   = 6'b010000,
    ST_OUT     = 6'b100000
  } state_t;

  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SER_LO);
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SER_HI);
  localparam logic signed [SER_W:0]   D_MAX  = (SER_W+1)'(DIFF_LIMIT);
  localparam logic signed [SER_W:0]   D_MIN  = -(SER_W+1)'(DIFF_LIMIT);

  state_t state_r, state_nxt;

  // Captured request
  logic [1:0]                   mode_r, mode_nxt;
  logic [13:0]                  by_r, by_nxt, oy_r, oy_nxt;
  logic [3:0]                   bm_r, bm_nxt, om_r, om_nxt;
  logic [4:0]                   bd_r, bd_nxt, od_r, od_nxt;
  logic signed [COUNT_BITS-1:0] cnt_in_r, cnt_in_nxt;

  // Sequencer working registers
  logic [SER_W-1:0] rem_r, rem_nxt, acc_r, acc_nxt, sb_r, sb_nxt;
  logic [5:0]       qcnt_r, qcnt_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [3:0]       flag_r, flag_nxt;
  logic [3:0]       mo_r, mo_nxt;
  conv_t            kind_r, kind_nxt;
  logic             second_r, second_nxt;

  // Pending result
  logic [13:0]      ry_r, ry_nxt;
  logic [3:0]       rm_r, rm_nxt;
  logic [4:0]       rd_r, rd_nxt;
  logic [1:0]       rel_r, rel_nxt;
  logic [22:0]      rdiff_r, rdiff_nxt;
  logic             rerr_r, rerr_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Shared unit
  logic [SER_W-1:0] sub_a, sub_b;
  sub_res_t         sub_res;

  cda_sub_unit u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  // Combinational helpers
  logic [3:0]             sel_m;
  logic [4:0]             sel_d;
  logic                   leap_ser, leap_date, cap_hit;
  logic [SER_W-1:0]       ser_val;
  logic signed [SUM_W-1:0] sum_b, sum_c, sum_t;
  logic signed [SER_W:0]  dd;
  logic [3:0]             cbm, com;
  logic [1:0]             rel_c;
  logic [4:0]             mlen;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign leap_ser  = flag_r[2] & (~flag_r[1] | flag_r[0]);
  assign leap_date = flag_r[3] & (~flag_r[2] | flag_r[1]);

  // Date being converted to a serial
  assign sel_m = clamp_month(second_r ? om_r : bm_r);
  assign sel_d = second_r ? od_r : bd_r;

  assign ser_val = acc_r + SER_W'(days_before(sel_m))
                 + SER_W'((sel_m > 4'd2) && leap_ser) + SER_W'(sel_d) - SER_W'(1);

  assign dd = $signed({1'b0, sb_r}) - $signed({1'b0, ser_val});

  // Shifted serial
  assign sum_b = $signed({{(SUM_W-SER_W){1'b0}}, sb_r});
  assign sum_c = SUM_W'(cnt_in_r);
  assign sum_t = (mode_r == MODE_ADD) ? (sum_b + sum_c) : (sum_b - sum_c);

  // Compare from the input fields directly
  assign cbm = clamp_month(in_tdata[17:14]);
  assign com = clamp_month(in_tdata[40:37]);
  always_comb begin
    if (in_tdata[13:0] != in_tdata[36:23])
      rel_c = (in_tdata[13:0] > in_tdata[36:23]) ? REL_GREAT : REL_LESS;
    else if (cbm != com)
      rel_c = (cbm > com) ? REL_GREAT : REL_LESS;
    else if (in_tdata[22:18] != in_tdata[45:41])
      rel_c = (in_tdata[22:18] > in_tdata[45:41]) ? REL_GREAT : REL_LESS;
    else
      rel_c = REL_EQ;
  end

  assign mlen    = month_len(mo_r) + 5'((mo_r == MONTH_FEB_IDX) && leap_date);
  assign cap_hit = (kind_r == CONV_DATE) && (phase_r[0]) && (qcnt_r == 6'd3);

  // Shared unit operands
  always_comb begin
    sub_a = rem_r;
    sub_b = (state_r == ST_MONTH) ? SER_W'(mlen) : phase_div(kind_r, phase_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    by_nxt        = by_r;
    bm_nxt        = bm_r;
    bd_nxt        = bd_r;
    oy_nxt        = oy_r;
    om_nxt        = om_r;
    od_nxt        = od_r;
    cnt_in_nxt    = cnt_in_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    sb_nxt        = sb_r;
    qcnt_nxt      = qcnt_r;
    phase_nxt     = phase_r;
    flag_nxt      = flag_r;
    mo_nxt        = mo_r;
    kind_nxt      = kind_r;
    second_nxt    = second_r;
    ry_nxt        = ry_r;
    rm_nxt        = rm_r;
    rd_nxt        = rd_r;
    rel_nxt       = rel_r;
    rdiff_nxt     = rdiff_r;
    rerr_nxt      = rerr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_tuser;
          by_nxt     = in_tdata[13:0];
          bm_nxt     = in_tdata[17:14];
          bd_nxt     = in_tdata[22:18];
          oy_nxt     = in_tdata[36:23];
          om_nxt     = in_tdata[40:37];
          od_nxt     = in_tdata[45:41];
          cnt_in_nxt = in_tdata[46 +: COUNT_BITS];
          ry_nxt     = '0;
          rm_nxt     = '0;
          rd_nxt     = '0;
          rel_nxt    = REL_EQ;
          rdiff_nxt  = '0;
          rerr_nxt   = 1'b0;
          // start the base date conversion
          rem_nxt    = SER_W'(in_tdata[13:0]) + SER_W'(YEAR_BIAS);
          acc_nxt    = '0;
          qcnt_nxt   = '0;
          phase_nxt  = '0;
          kind_nxt   = CONV_SERIAL;
          second_nxt = 1'b0;
          if (in_tuser == MODE_CMP) begin
            rel_nxt   = rel_c;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end

      // one subtraction per cycle, four phases of decreasing divisor
      ST_DIV: begin
        if (sub_res.ge && !cap_hit) begin
          rem_nxt  = sub_res.diff;
          acc_nxt  = acc_r + phase_inc(kind_r, phase_r);
          qcnt_nxt = qcnt_r + 6'd1;
        end else begin
          flag_nxt[phase_r] = (kind_r == CONV_DATE) ? (qcnt_r == quo_mark(phase_r))
                                                    : (rem_r == rem_mark(phase_r));
          qcnt_nxt  = '0;
          phase_nxt = phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            if (kind_r == CONV_DATE) begin
              mo_nxt    = '0;
              state_nxt = ST_MONTH;
            end else begin
              state_nxt = ST_SER_END;
            end
          end
        end
      end

      ST_SER_END: begin
        if (second_r) begin
          if (dd > D_MAX) rdiff_nxt = D_MAX[22:0];
          else if (dd < D_MIN) rdiff_nxt = D_MIN[22:0];
          else rdiff_nxt = dd[22:0];
          state_nxt = ST_OUT;
        end else begin
          sb_nxt = ser_val;
          if (mode_r == MODE_DIFF) begin
            second_nxt = 1'b1;
            rem_nxt    = SER_W'(oy_r) + SER_W'(YEAR_BIAS);
            acc_nxt    = '0;
            qcnt_nxt   = '0;
            phase_nxt  = '0;
            state_nxt  = ST_DIV;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (sum_t < SUM_LO || sum_t >= SUM_HI) begin
          rerr_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          rem_nxt   = sum_t[SER_W-1:0];
          acc_nxt   = '0;
          qcnt_nxt  = '0;
          phase_nxt = '0;
          kind_nxt  = CONV_DATE;
          state_nxt = ST_DIV;
        end
      end

      // walk the months of the year
      ST_MONTH: begin
        if (!sub_res.ge || mo_r == MONTH_DEC_IDX) begin
          ry_nxt    = 14'(acc_r - SER_W'(YEAR_BIAS));
          rm_nxt    = mo_r + 4'd1;
          rd_nxt    = 5'(rem_r) + 5'd1;
          state_nxt = ST_OUT;
        end else begin
          rem_nxt = sub_res.diff;
          mo_nxt  = mo_r + 4'd1;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({rerr_r, rdiff_r, rel_r, rd_r, rm_r, ry_r});
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    by_r       <= by_nxt;
    bm_r       <= bm_nxt;
    bd_r       <= bd_nxt;
    oy_r       <= oy_nxt;
    om_r       <= om_nxt;
    od_r       <= od_nxt;
    cnt_in_r   <= cnt_in_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    sb_r       <= sb_nxt;
    qcnt_r     <= qcnt_nxt;
    phase_r    <= phase_nxt;
    flag_r     <= flag_nxt;
    mo_r       <= mo_nxt;
    kind_r     <= kind_nxt;
    second_r   <= second_nxt;
    ry_r       <= ry_nxt;
    rm_r       <= rm_nxt;
    rd_r       <= rd_nxt;
    rel_r      <= rel_nxt;
    rdiff_r    <= rdiff_nxt;
    rerr_r     <= rerr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/cda_sub_unit.sv =====
// Shared subtract-and-compare unit of the date sequencer.
// Depends on cda_pkg.
module cda_sub_unit (
  input  logic [cda_pkg::SER_W-1:0] a,
  input  logic [cda_pkg::SER_W-1:0] b,
  output cda_pkg::sub_res_t         res
);
  import cda_pkg::*;

  logic [SER_W:0] wide;

  // a - b with borrow; ge when no borrow
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[SER_W-1:0];
  assign res.ge   = ~wide[SER_W];

endmodule

// ===== bench/tb_calendar_date_arithmetic_top.sv =====
// Self-checking bench for calendar_date_arithmetic_top: a directed table of
// requests followed by random ones, each result checked against a typed-in value or a local date predictor.
// Depends on cda_pkg and the RTL of the block only.
module tb_calendar_date_arithmetic_top;
  import cda_pkg::*;

  typedef struct {
    mode_t                  mode;
    logic [13:0]            by;
    logic [3:0]             bm;
    logic [4:0]             bd;
    logic [13:0]            oy;
    logic [3:0]             om;
    logic [4:0]             od;
    logic [COUNT_BITS-1:0]  cnt;
  } date_req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  rel;
    logic [22:0] diff;
    logic        rerr;
  } date_res_t;

  // directed row: request plus an optional typed-in result
  typedef struct {
    date_req_t req;
    bit        fixed;
    date_res_t res;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;

  date_res_t pending_dates[$];
  int  mismatches = 0;
  bit  sending_done = 0;
  bit  hold_receiver = 0;
  bit  no_idle = 0;

  calendar_date_arithmetic_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // ---- predictor ----
  function automatic bit leap_year(longint y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic longint fix_month(logic [3:0] m);
    if (m == 0) return 1;
    if (m > 12) return 12;
    return m;
  endfunction

  function automatic longint month_days(longint mi, longint y);
    longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return lens[mi] + ((mi == 1 && leap_year(y)) ? 1 : 0);
  endfunction

  // day number, years shifted by 400
  function automatic longint day_number(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
    longint y, m, p, s;
    y = longint'(yr) + 400;
    m = fix_month(mo);
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400;
    for (int i = 0; i < m - 1; i++) s += month_days(i, y);
    return s + longint'(dy) - 1;
  endfunction

  function automatic date_res_t shifted_date(date_req_t r);
    date_res_t o;
    longint n, c, q, year, mi;
    o = '{default: 0};
    c = longint'(signed'(r.cnt));
    if (r.mode == MODE_CMP) begin
      if (r.by != r.oy) o.rel = (r.by > r.oy) ? REL_GREAT : REL_LESS;
      else if (fix_month(r.bm) != fix_month(r.om))
        o.rel = (fix_month(r.bm) > fix_month(r.om)) ? REL_GREAT : REL_LESS;
      else if (r.bd != r.od) o.rel = (r.bd > r.od) ? REL_GREAT : REL_LESS;
      else o.rel = REL_EQ;
    end else if (r.mode == MODE_DIFF) begin
      n = day_number(r.by, r.bm, r.bd) - day_number(r.oy, r.om, r.od);
      if (n > DIFF_LIMIT) n = DIFF_LIMIT;
      if (n < -DIFF_LIMIT) n = -DIFF_LIMIT;
      o.diff = n[22:0];
    end else begin
      n = day_number(r.by, r.bm, r.bd) + ((r.mode == MODE_ADD) ? c : -c);
      if (n < day_number(1, 1, 1) || n >= day_number(10000, 1, 1)) begin
        o.rerr = 1;
      end else begin
        q = n / 146097; n -= q * 146097; year = q * 400;
        q = n / 36524; if (q > 3) q = 3; n -= q * 36524; year += q * 100;
        q = n / 1461; n -= q * 1461; year += q * 4;
        q = n / 365; if (q > 3) q = 3; n -= q * 365; year += q + 1;
        mi = 0;
        while (mi < 11 && n >= month_days(mi, year)) begin
          n -= month_days(mi, year);
          mi++;
        end
        o.year = 14'(year - 400);
        o.month = 4'(mi + 1);
        o.day = 5'(n + 1);
      end
    end
    return o;
  endfunction

  // ---- sender ----
  // valid stays high from one request to the next unless an idle gap is taken
  task automatic send_request(date_req_t r, date_res_t want);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 13);
    end
    in_tvalid <= 1;
    in_tuser  <= r.mode;
    in_tdata  <= IN_DATA_W'({r.cnt, r.od, r.om, r.oy, r.bd, r.bm, r.by});
    do @(posedge clk); while (!in_tready);
    pending_dates.push_back(want);
  endtask

  function automatic date_req_t random_request();
    date_req_t r;
    int k;
    r.mode = mode_t'($urandom_range(3));
    k = $urandom_range(9);
    r.by = (k == 0) ? 14'($urandom) : 14'($urandom_range(9999, 1));
    r.oy = (k == 1) ? 14'($urandom) : 14'($urandom_range(9999, 1));
    r.bm = (k == 2) ? 4'($urandom) : 4'($urandom_range(12, 1));
    r.om = (k == 3) ? 4'($urandom) : 4'($urandom_range(12, 1));
    r.bd = (k == 4) ? 5'($urandom) : 5'($urandom_range(28, 1));
    r.od = (k == 5) ? 5'($urandom) : 5'($urandom_range(28, 1));
    if ($urandom_range(3) == 0) r.oy = r.by;
    if ($urandom_range(1)) r.cnt = COUNT_BITS'($urandom);
    else r.cnt = COUNT_BITS'(int'($urandom_range(2000)) - 1000);
    return r;
  endfunction

  function automatic date_req_t mk(mode_t m, int by, int bm, int bd, int oy, int om,
                                   int od, int cnt);
    date_req_t r;
    r.mode = m; r.by = 14'(by); r.bm = 4'(bm); r.bd = 5'(bd);
    r.oy = 14'(oy); r.om = 4'(om); r.od = 5'(od); r.cnt = COUNT_BITS'(cnt);
    return r;
  endfunction

  initial begin
    table_row_t rows[$];
    table_row_t row;
    date_req_t r;
    date_res_t z;
    z = '{default: 0};
    // directed table: fixed expectations where obvious
    row.fixed = 1; row.res = z; row.res.rel = REL_EQ;
    row.req = mk(MODE_CMP, 2000, 2, 29, 2000, 2, 29, 0); rows.push_back(row);
    row.res.rel = REL_LESS;
    row.req = mk(MODE_CMP, 1, 1, 1, 9999, 12, 31, 0); rows.push_back(row);
    row.res.rel = REL_GREAT;
    row.req = mk(MODE_CMP, 16383, 15, 31, 0, 0, 0, 0); rows.push_back(row);
    row.res = z; row.res.rerr = 1;
    row.req = mk(MODE_SUB, 1, 1, 1, 0, 0, 0, 1); rows.push_back(row);
    row.req = mk(MODE_ADD, 9999, 12, 31, 0, 0, 0, 1); rows.push_back(row);
    row.req = mk(MODE_ADD, 1, 1, 1, 0, 0, 0, -1); rows.push_back(row);
    row.req = mk(MODE_SUB, 9999, 1, 1, 0, 0, 0, -1048576); rows.push_back(row);
    row.res = z; row.res.year = 1; row.res.month = 1; row.res.day = 1;
    row.req = mk(MODE_ADD, 1, 1, 1, 0, 0, 0, 0); rows.push_back(row);
    row.res = z; row.res.diff = 23'(DIFF_LIMIT);
    row.req = mk(MODE_DIFF, 16383, 15, 31, 0, 0, 0, 0); rows.push_back(row);
    row.res.diff = 23'(-DIFF_LIMIT);
    row.req = mk(MODE_DIFF, 0, 0, 0, 16383, 15, 31, 0); rows.push_back(row);
    row.fixed = 0;
    row.req = mk(MODE_ADD, 2000, 2, 28, 0, 0, 0, 1); rows.push_back(row);
    row.req = mk(MODE_ADD, 1900, 2, 28, 0, 0, 0, 1); rows.push_back(row);
    row.req = mk(MODE_ADD, 2023, 2, 31, 0, 0, 0, 0); rows.push_back(row);
    row.req = mk(MODE_SUB, 2024, 3, 0, 0, 0, 0, 0); rows.push_back(row);
    row.req = mk(MODE_ADD, 5000, 0, 15, 0, 0, 0, 1048575); rows.push_back(row);
    row.req = mk(MODE_SUB, 5000, 13, 15, 0, 0, 0, -1048575); rows.push_back(row);
    row.req = mk(MODE_DIFF, 2024, 1, 1, 2023, 1, 1, 0); rows.push_back(row);
    row.req = mk(MODE_DIFF, 1, 1, 1, 9999, 12, 31, 0); rows.push_back(row);
    row.req = mk(MODE_CMP, 2024, 0, 5, 2024, 1, 4, 0); rows.push_back(row);
    row.req = mk(MODE_CMP, 2024, 13, 5, 2024, 12, 6, 0); rows.push_back(row);

    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i])
      send_request(rows[i].req, rows[i].fixed ? rows[i].res : shifted_date(rows[i].req));
    in_tvalid <= 0;
    // pause until the block has drained
    while (pending_dates.size() != 0) @(posedge clk);
    // receiver holds off while the first ten random requests are sent
    hold_receiver = 1;
    for (int i = 0; i < 100; i++) begin
      if (i == 10) hold_receiver = 0;
      no_idle = (i >= 40 && i < 70);
      r = random_request();
      send_request(r, shifted_date(r));
    end
    in_tvalid <= 0;
    sending_done = 1;
  end

  // ---- receiver ----
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_receiver && stall < 2000) begin
        stall++;
        out_tready <= 0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 13);
      end
    end
  end

  // ---- checker ----
  always @(posedge clk) begin
    date_res_t want;
    date_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      {got.rerr, got.diff, got.rel, got.day, got.month, got.year} =
        out_tdata[OUT_FIELDS_W-1:0];
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = pending_dates.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp y%0d m%0d d%0d rel%0d diff%0d err%0d,",
                      " got y%0d m%0d d%0d rel%0d diff%0d err%0d"},
                     want.year, want.month, want.day, want.rel, signed'(want.diff),
                     want.rerr, got.year, got.month, got.day, got.rel,
                     signed'(got.diff), got.rerr);
        end
      end
    end
  end

  // ---- end of run ----
  initial begin
    wait (sending_done);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
